// ===== rtl/rfsfw_pkg.sv =====
// Shared types, band tables and constants for the synthesizer frequency word pipeline.
// No dependencies; imported by rfsfw_divider and rf_synth_frequency_words.
package rfsfw_pkg;

    // result status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_RANGE  = 2'd1;
    localparam logic [1:0] ST_NOBAND = 2'd2;
    localparam logic [1:0] ST_RATE   = 2'd3;

    localparam logic [2:0] RATE_INVALID = 3'd7;

    localparam int NUM_BANDS = 6;
    localparam int NUM_GAPS  = 5;
    localparam int NUM_WIN   = 3;
    localparam int NUM_RATES = 7;

    // divider geometry: quotient = floor(freq * 2^19 / step), 7 integer + 19 fraction bits
    localparam int FRAC_BITS = 19;
    localparam int FBITS_W   = 7;
    localparam int QUOT_W    = FBITS_W + FRAC_BITS;
    localparam int REM_W     = 24;
    localparam int DEV_W     = 17;
    localparam int FRAC_W    = 24;

    localparam logic [31:0] TWO_XO_HZ = 32'd60000000;

    // tunable window in hertz, lower bound inclusive, upper bound exclusive
    localparam logic [31:0] WIN_LO [NUM_WIN] = '{32'd142000000, 32'd284000000, 32'd850000000};
    localparam logic [31:0] WIN_HI [NUM_WIN] = '{32'd176000000, 32'd526000000, 32'd1051000000};

    // open gaps between neighboring nominal bands, same bound convention
    localparam logic [31:0] GAP_LO [NUM_GAPS] = '{32'd151000000, 32'd226000000,
                                                  32'd301000000, 32'd451000000,
                                                  32'd601000000};
    localparam logic [31:0] GAP_HI [NUM_GAPS] = '{32'd225000000, 32'd300000000,
                                                  32'd450000000, 32'd600000000,
                                                  32'd900000000};
    // at or above the midpoint the upper band wins
    localparam logic [31:0] GAP_MID [NUM_GAPS] = '{32'd187500000, 32'd262500000,
                                                   32'd375000000, 32'd525000000,
                                                   32'd750000000};

    localparam logic [4:0] BAND_DIV [NUM_BANDS] = '{5'd24, 5'd16, 5'd12, 5'd8, 5'd6, 5'd4};

    // synthesizer step per band: 2 * xo / divider
    localparam logic [REM_W-1:0] BAND_STEP [NUM_BANDS] = '{
        REM_W'(TWO_XO_HZ / 24), REM_W'(TWO_XO_HZ / 16), REM_W'(TWO_XO_HZ / 12),
        REM_W'(TWO_XO_HZ / 8),  REM_W'(TWO_XO_HZ / 6),  REM_W'(TWO_XO_HZ / 4)};

    localparam logic [17:0] HALF_RATE [NUM_RATES] = '{18'd250, 18'd2400, 18'd4800,
                                                      18'd20000, 18'd50000, 18'd60000,
                                                      18'd250000};

    localparam logic [63:0] DEV_DEN_TWO  = 64'd60000000;
    localparam logic [63:0] DEV_DEN_FOUR = 64'd180000000;
    localparam logic [63:0] FRAC_ONE_64  = 64'd1 << FRAC_BITS;
    localparam logic [FRAC_W-1:0] FRAC_ONE = FRAC_W'(1) << FRAC_BITS;

    // deviation words indexed by [four_level][band][rate]
    typedef logic [1:0][NUM_BANDS-1:0][NUM_RATES-1:0][DEV_W-1:0] dev_tab_t;

    function automatic dev_tab_t build_dev_tab();
        dev_tab_t   tab;
        logic [63:0] num;
        tab = '0;
        for (int b = 0; b < NUM_BANDS; b++) begin
            for (int r = 0; r < NUM_RATES; r++) begin
                num = FRAC_ONE_64 * 64'(BAND_DIV[b]) * 64'(HALF_RATE[r]);
                tab[0][b][r] = DEV_W'(num / DEV_DEN_TWO);
                tab[1][b][r] = DEV_W'(num / DEV_DEN_FOUR);
            end
        end
        return tab;
    endfunction

    localparam dev_tab_t DEV_TAB = build_dev_tab();

    // fields that ride alongside the divider
    typedef struct packed {
        logic [1:0]       status;
        logic [2:0]       band;
        logic [DEV_W-1:0] dev;
    } side_t;

endpackage

// ===== rtl/rfsfw_divider.sv =====
// Pipelined restoring divider: one quotient bit per stage, freq * 2^19 / band step.
// Depends on rfsfw_pkg for widths, the band step table and the side_t struct.
module rfsfw_divider
    import rfsfw_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 advance,
    input  logic                 in_valid,
    input  logic [FBITS_W-1:0]   in_fbits,
    input  logic [REM_W-1:0]     in_rem,
    input  side_t                in_side,
    output logic                 out_valid,
    output logic [QUOT_W-1:0]    out_quot,
    output side_t                out_side
);

    logic [QUOT_W-1:0]  valid_reg;
    logic [QUOT_W-1:0]  valid_next;
    logic [REM_W-1:0]   rem_reg  [QUOT_W];
    logic [REM_W-1:0]   rem_next [QUOT_W];
    logic [FBITS_W-1:0] fb_reg   [QUOT_W];
    logic [FBITS_W-1:0] fb_next  [QUOT_W];
    logic [QUOT_W-1:0]  q_reg    [QUOT_W];
    logic [QUOT_W-1:0]  q_next   [QUOT_W];
    side_t              side_reg [QUOT_W];
    side_t              side_next[QUOT_W];

    // compare and subtract per stage, dividend bits shifted in from the top
    always_comb
    begin
        logic [REM_W-1:0]   src_rem;
        logic [FBITS_W-1:0] src_fb;
        logic [QUOT_W-1:0]  src_q;
        side_t              src_side;
        logic [REM_W:0]     trial;
        logic [REM_W:0]     divisor;
        logic [REM_W:0]     diff;
        logic               ge;
        for (int j = 0; j < QUOT_W; j++)
        begin
            if (j == 0)
            begin
                src_rem  = in_rem;
                src_fb   = in_fbits;
                src_q    = '0;
                src_side = in_side;
            end
            else
            begin
                src_rem  = rem_reg[j-1];
                src_fb   = fb_reg[j-1];
                src_q    = q_reg[j-1];
                src_side = side_reg[j-1];
            end
            divisor      = {1'b0, BAND_STEP[src_side.band]};
            trial        = {src_rem, src_fb[FBITS_W-1]};
            diff         = trial - divisor;
            ge           = (trial >= divisor);
            rem_next[j]  = ge ? diff[REM_W-1:0] : trial[REM_W-1:0];
            fb_next[j]   = {src_fb[FBITS_W-2:0], 1'b0};
            q_next[j]    = {src_q[QUOT_W-2:0], ge};
            side_next[j] = src_side;
        end
    end

    assign valid_next = {valid_reg[QUOT_W-2:0], in_valid};

    // stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (advance)
        begin
            valid_reg <= valid_next;
        end
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int j = 0; j < QUOT_W; j++)
            begin
                rem_reg[j]  <= rem_next[j];
                fb_reg[j]   <= fb_next[j];
                q_reg[j]    <= q_next[j];
                side_reg[j] <= side_next[j];
            end
        end
    end

    assign out_valid = valid_reg[QUOT_W-1];
    assign out_quot  = q_reg[QUOT_W-1];
    assign out_side  = side_reg[QUOT_W-1];

endmodule

// ===== rtl/rf_synth_frequency_words.sv =====
// Top level: synthesizer integer, fractional and deviation words from a carrier frequency.
// Depends on rfsfw_pkg and rfsfw_divider.
//
//  channel | handshake            | payload
//  --------+----------------------+-----------------------------------------------------
//  input   | in_valid / in_ready  | freq_hz, four_level, rate_code
//  output  | out_valid / out_ready| status, band_index, int_word, frac_word, dev_word
//
// One item enters per cycle while the output register is not stalled; each result
// passes band classification (loaded at the transfer edge), table lookup, 26 divider
// stages of one quotient bit each and the output register, in that order.
// Reset clears only the valid bits of every stage.
// A stalled output register freezes all stages together; in_ready follows it.
module rf_synth_frequency_words
    import rfsfw_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [31:0]       freq_hz,
    input  logic              four_level,
    input  logic [2:0]        rate_code,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [1:0]        status,
    output logic [2:0]        band_index,
    output logic [6:0]        int_word,
    output logic [FRAC_W-1:0] frac_word,
    output logic [DEV_W-1:0]  dev_word
);

    logic advance;

    logic        s1_valid_reg;
    logic [31:0] s1_freq_reg;
    logic        s1_four_reg;
    logic [2:0]  s1_rate_reg;
    logic [1:0]  s1_status_reg;
    logic [1:0]  s1_status_next;
    logic [2:0]  s1_band_reg;
    logic [2:0]  s1_band_next;

    logic               s2_valid_reg;
    logic [FBITS_W-1:0] s2_fbits_reg;
    logic [REM_W-1:0]   s2_rem_reg;
    side_t              s2_side_reg;
    side_t              s2_side_next;

    logic              div_valid;
    logic [QUOT_W-1:0] div_quot;
    side_t             div_side;

    logic              out_valid_reg;
    logic [1:0]        status_reg;
    logic [2:0]        band_reg;
    logic [6:0]        int_reg;
    logic [FRAC_W-1:0] frac_reg;
    logic [DEV_W-1:0]  dev_reg;
    logic [2:0]        band_next;
    logic [6:0]        int_next;
    logic [FRAC_W-1:0] frac_next;
    logic [DEV_W-1:0]  dev_next;

    // whole pipeline moves unless a result waits at the output
    assign advance  = !out_valid_reg || out_ready;
    assign in_ready = advance;

    // window check and nearest band from plain compares
    always_comb
    begin
        logic win;
        logic found;
        win          = 1'b0;
        found        = 1'b0;
        s1_band_next = '0;
        for (int w = 0; w < NUM_WIN; w++)
        begin
            if (freq_hz >= WIN_LO[w] && freq_hz < WIN_HI[w])
            begin
                win = 1'b1;
            end
        end
        for (int g = 0; g < NUM_GAPS; g++)
        begin
            if (!found && freq_hz >= GAP_LO[g] && freq_hz < GAP_HI[g])
            begin
                found        = 1'b1;
                s1_band_next = (freq_hz >= GAP_MID[g]) ? 3'(g + 1) : 3'(g);
            end
        end
        if (!win)
        begin
            s1_status_next = ST_RANGE;
        end
        else if (!found)
        begin
            s1_status_next = ST_NOBAND;
        end
        else if (rate_code == RATE_INVALID)
        begin
            s1_status_next = ST_RATE;
        end
        else
        begin
            s1_status_next = ST_OK;
        end
    end

    // deviation lookup and divider setup
    always_comb
    begin
        logic [2:0] rate_idx;
        rate_idx             = (s1_rate_reg == RATE_INVALID) ? 3'd0 : s1_rate_reg;
        s2_side_next.status  = s1_status_reg;
        s2_side_next.band    = s1_band_reg;
        s2_side_next.dev     = (s1_status_reg == ST_OK) ?
                               DEV_TAB[s1_four_reg][s1_band_reg][rate_idx] : '0;
    end

    // valid bits of the front stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    // front stage payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_freq_reg   <= freq_hz;
            s1_four_reg   <= four_level;
            s1_rate_reg   <= rate_code;
            s1_status_reg <= s1_status_next;
            s1_band_reg   <= s1_band_next;
            s2_fbits_reg  <= s1_freq_reg[FBITS_W-1:0];
            s2_rem_reg    <= s1_freq_reg[FBITS_W +: REM_W];
            s2_side_reg   <= s2_side_next;
        end
    end

    rfsfw_divider u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .in_valid  (s2_valid_reg),
        .in_fbits  (s2_fbits_reg),
        .in_rem    (s2_rem_reg),
        .in_side   (s2_side_reg),
        .out_valid (div_valid),
        .out_quot  (div_quot),
        .out_side  (div_side)
    );

    // split quotient into words, clear fields for range and band errors
    always_comb
    begin
        logic no_result;
        no_result = (div_side.status == ST_RANGE) || (div_side.status == ST_NOBAND);
        band_next = no_result ? 3'd0 : div_side.band;
        int_next  = no_result ? 7'd0 : (div_quot[QUOT_W-1:FRAC_BITS] - 7'd1);
        frac_next = no_result ? '0 :
                    (FRAC_ONE | {{(FRAC_W-FRAC_BITS){1'b0}}, div_quot[FRAC_BITS-1:0]});
        dev_next  = div_side.dev;
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= div_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            status_reg <= div_side.status;
            band_reg   <= band_next;
            int_reg    <= int_next;
            frac_reg   <= frac_next;
            dev_reg    <= dev_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign band_index = band_reg;
    assign int_word   = int_reg;
    assign frac_word  = frac_reg;
    assign dev_word   = dev_reg;

endmodule
